// ----- sv/fa2q_pkg.sv -----
// shared types and constants for the fixed-point atan2 pipeline
// no dependencies; imported by the divider and the top level
package fa2q_pkg;

  localparam int unsigned MAG_W  = 32;
  localparam int unsigned QUOT_W = 17;
  localparam int unsigned COEF_W = 18;
  localparam int unsigned ACC_W  = 24;
  localparam int unsigned ANG_W  = 19;

  localparam logic signed [ACC_W-1:0] ANG_PI   = 24'sd205887;
  localparam logic signed [ACC_W-1:0] ANG_PI_2 = 24'sd102944;
  localparam logic signed [ACC_W-1:0] ANG_PI_4 = 24'sd51472;

  localparam logic signed [COEF_W-1:0] COEF_LINEAR_RST  = 18'sd65500;
  localparam logic signed [COEF_W-1:0] COEF_CUBIC_RST   = -18'sd21758;
  localparam logic signed [COEF_W-1:0] COEF_FIFTH_RST   = 18'sd5462;
  localparam logic signed [COEF_W-1:0] COEF_SEVENTH_RST = -18'sd1024;

  typedef enum logic [1:0] {
    REG_LINEAR  = 2'd0,
    REG_CUBIC   = 2'd1,
    REG_FIFTH   = 2'd2,
    REG_SEVENTH = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_GENERAL,
    KIND_ZERO,
    KIND_X_ZERO,
    KIND_Y_ZERO
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  x_neg;
    logic  y_neg;
    logic  y_larger;
  } side_t;

endpackage

// ----- sv/fa2q_if.sv -----
// valid/ready channel interfaces for the atan2 pipeline
// input beat carries y and x, result beat carries the angle
interface fa2q_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] y_value;
  logic signed [31:0] x_value;
  modport source (output valid, y_value, x_value, input ready);
  modport sink   (input valid, y_value, x_value, output ready);
endinterface

interface fa2q_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] angle;
  modport source (output valid, angle, input ready);
  modport sink   (input valid, angle, output ready);
endinterface

// ----- sv/fa2q_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// quotient = (num << 16) / den for num <= den; uses fa2q_pkg
module fa2q_div
  import fa2q_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [MAG_W-1:0]  in_num,
  input  logic [MAG_W-1:0]  in_den,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [QUOT_W-1:0] out_quot,
  output side_t             out_side
);

  logic              valid_r [QUOT_W];
  logic [MAG_W-1:0]  rem_r   [QUOT_W];
  logic [MAG_W-1:0]  den_r   [QUOT_W];
  logic [QUOT_W-1:0] quot_r  [QUOT_W];
  side_t             side_r  [QUOT_W];

  genvar k;
  generate
    for (k = 0; k < QUOT_W; k++) begin : g_step
      logic              v_in;
      logic [MAG_W:0]    trial;
      logic [MAG_W-1:0]  den_in;
      logic [QUOT_W-1:0] q_in;
      side_t             s_in;
      logic              ge;
      logic [MAG_W:0]    diff;

      if (k == 0) begin : g_first
        assign v_in   = in_valid;
        assign trial  = {1'b0, in_num};
        assign den_in = in_den;
        assign q_in   = '0;
        assign s_in   = in_side;
      end else begin : g_next
        // remainder stays below den, so the shift never overflows
        assign v_in   = valid_r[k-1];
        assign trial  = {rem_r[k-1], 1'b0};
        assign den_in = den_r[k-1];
        assign q_in   = quot_r[k-1];
        assign s_in   = side_r[k-1];
      end

      assign diff = trial - {1'b0, den_in};
      assign ge   = (trial >= {1'b0, den_in});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[k] <= 1'b0;
        end else if (en) begin
          valid_r[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
          den_r[k]  <= den_in;
          quot_r[k] <= {q_in[QUOT_W-2:0], ge};
          side_r[k] <= s_in;
        end
      end
    end
  endgenerate

  assign out_valid = valid_r[QUOT_W-1];
  assign out_quot  = quot_r[QUOT_W-1];
  assign out_side  = side_r[QUOT_W-1];

endmodule

// ----- sv/fixed_atan2_q16.sv -----
// fixed_atan2_q16: four-quadrant arctangent of signed Q16.16 (y, x)
// beat in: in_chan carries y_value and x_value, taken when valid and ready
// beat out: out_chan carries angle, signed Q16.16 in 19 bits, about -pi..pi
// coefficients of the odd atan polynomial are written through cfg_we,
// cfg_index (0 linear, 1 cubic, 2 fifth, 3 seventh) and cfg_data; the user
// must write them only while no beat is in flight; the block itself does
// not enforce it
// path: a magnitude and classification stage, the divider (one quotient
//   bit per stage), 5 polynomial stages and an output stage
// throughput: one beat per cycle; the pipeline advances as one whole
//   whenever the output register is empty or being taken
// when the receiver stalls with a result waiting, every stage holds and
//   in_chan.ready drops; nothing is lost or repeated
// reset clears all valid bits and loads the default coefficients
// depends on fa2q_pkg, fa2q_if and fa2q_div
module fixed_atan2_q16
  import fa2q_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  fa2q_in_if.sink           in_chan,
  fa2q_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [COEF_W-1:0] cfg_data
);

  logic en;

  // configuration registers
  logic signed [COEF_W-1:0] c1_r, c3_r, c5_r, c7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= COEF_LINEAR_RST;
      c3_r <= COEF_CUBIC_RST;
      c5_r <= COEF_FIFTH_RST;
      c7_r <= COEF_SEVENTH_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LINEAR:  c1_r <= cfg_data;
        REG_CUBIC:   c3_r <= cfg_data;
        REG_FIFTH:   c5_r <= cfg_data;
        REG_SEVENTH: c7_r <= cfg_data;
        default:     c1_r <= c1_r;
      endcase
    end
  end

  // stage 0: magnitudes, ordering and special cases
  logic             s0_valid_r;
  logic [MAG_W-1:0] s0_num_r, s0_den_r;
  side_t            s0_side_r;

  logic [MAG_W-1:0] ay, ax;
  side_t            side_nxt;

  always_comb begin
    ay = in_chan.y_value[31] ? (~in_chan.y_value + 32'd1) : in_chan.y_value;
    ax = in_chan.x_value[31] ? (~in_chan.x_value + 32'd1) : in_chan.x_value;
    side_nxt.x_neg    = in_chan.x_value[31];
    side_nxt.y_neg    = in_chan.y_value[31];
    side_nxt.y_larger = (ay > ax);
    priority if (ax == '0 && ay == '0) begin
      side_nxt.kind = KIND_ZERO;
    end else if (ax == '0) begin
      side_nxt.kind = KIND_X_ZERO;
    end else if (ay == '0) begin
      side_nxt.kind = KIND_Y_ZERO;
    end else begin
      side_nxt.kind = KIND_GENERAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_num_r  <= side_nxt.y_larger ? ax : ay;
      s0_den_r  <= side_nxt.y_larger ? ay : ax;
      s0_side_r <= side_nxt;
    end
  end

  // ratio
  logic              dv_valid;
  logic [QUOT_W-1:0] dv_quot;
  side_t             dv_side;

  fa2q_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_valid_r),
    .in_num    (s0_num_r),
    .in_den    (s0_den_r),
    .in_side   (s0_side_r),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // polynomial stages
  logic        p1_valid_r, p2_valid_r, p3_valid_r, p4_valid_r, p5_valid_r;
  side_t       p1_side_r, p2_side_r, p3_side_r, p4_side_r, p5_side_r;
  logic        p1_one_r, p2_one_r, p3_one_r, p4_one_r;
  logic        p1_zero_r, p2_zero_r, p3_zero_r, p4_zero_r;
  logic [15:0] p1_r_r, p2_r_r, p3_r_r, p4_r_r;
  logic [15:0] p1_r2_r, p2_r2_r, p3_r2_r;
  logic signed [ACC_W-1:0] p2_acc_r, p3_acc_r, p4_acc_r, p5_val_r;

  logic [31:0]             sq;
  logic signed [40:0]      prod2, prod3, prod4, prod5;
  logic signed [40:0]      sh2, sh3, sh4, sh5;
  logic signed [ACC_W-1:0] acc7;

  always_comb begin
    sq    = dv_quot[15:0] * dv_quot[15:0];
    acc7  = ACC_W'(c7_r);
    prod2 = acc7 * $signed({1'b0, p1_r2_r});
    prod3 = p2_acc_r * $signed({1'b0, p2_r2_r});
    prod4 = p3_acc_r * $signed({1'b0, p3_r2_r});
    prod5 = p4_acc_r * $signed({1'b0, p4_r_r});
    sh2   = prod2 >>> 16;
    sh3   = prod3 >>> 16;
    sh4   = prod4 >>> 16;
    sh5   = prod5 >>> 16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
      p4_valid_r <= 1'b0;
      p5_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= dv_valid;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
      p4_valid_r <= p3_valid_r;
      p5_valid_r <= p4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_side_r <= dv_side;
      p1_one_r  <= dv_quot[16];
      p1_zero_r <= (dv_quot == '0);
      p1_r_r    <= dv_quot[15:0];
      p1_r2_r   <= sq[31:16];

      p2_side_r <= p1_side_r;
      p2_one_r  <= p1_one_r;
      p2_zero_r <= p1_zero_r;
      p2_r_r    <= p1_r_r;
      p2_r2_r   <= p1_r2_r;
      p2_acc_r  <= sh2[ACC_W-1:0] + ACC_W'(c5_r);

      p3_side_r <= p2_side_r;
      p3_one_r  <= p2_one_r;
      p3_zero_r <= p2_zero_r;
      p3_r_r    <= p2_r_r;
      p3_r2_r   <= p2_r2_r;
      p3_acc_r  <= sh3[ACC_W-1:0] + ACC_W'(c3_r);

      p4_side_r <= p3_side_r;
      p4_one_r  <= p3_one_r;
      p4_zero_r <= p3_zero_r;
      p4_r_r    <= p3_r_r;
      p4_acc_r  <= sh4[ACC_W-1:0] + ACC_W'(c1_r);

      p5_side_r <= p4_side_r;
      priority if (p4_zero_r) begin
        p5_val_r <= '0;
      end else if (p4_one_r) begin
        p5_val_r <= ANG_PI_4;
      end else begin
        p5_val_r <= sh5[ACC_W-1:0];
      end
    end
  end

  // output stage: octant and quadrant folding
  logic                    out_valid_r;
  logic [ANG_W-1:0]        out_angle_r;
  logic signed [ACC_W-1:0] a_oct, a_quad, a_fin, ang_nxt;

  always_comb begin
    a_oct  = p5_side_r.y_larger ? (ANG_PI_2 - p5_val_r) : p5_val_r;
    a_quad = p5_side_r.x_neg ? (ANG_PI - a_oct) : a_oct;
    a_fin  = p5_side_r.y_neg ? -a_quad : a_quad;
    unique case (p5_side_r.kind)
      KIND_ZERO:    ang_nxt = '0;
      KIND_X_ZERO:  ang_nxt = p5_side_r.y_neg ? -ANG_PI_2 : ANG_PI_2;
      KIND_Y_ZERO:  ang_nxt = p5_side_r.x_neg ? ANG_PI : '0;
      KIND_GENERAL: ang_nxt = a_fin;
      default:      ang_nxt = a_fin;
    endcase
  end

  assign en = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_angle_r <= ang_nxt[ANG_W-1:0];
    end
  end

  assign in_chan.ready  = en;
  assign out_chan.valid = out_valid_r;
  assign out_chan.angle = out_angle_r;

endmodule
